[rtl/partitioned_csr_spmv_core_assert.svh]
// Assertion macros for the partitioned CSR SpMV core.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PARTITIONED_CSR_SPMV_CORE_ASSERT_SVH
`define PARTITIONED_CSR_SPMV_CORE_ASSERT_SVH

// Same-cycle implication.
`define PCSR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcsr assertion failed");

// Next-cycle implication.
`define PCSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcsr assertion failed");

`endif

[rtl/pcsr_pkg.sv]
// Shared types, constants and functions of the partitioned CSR SpMV core.
// Depends on nothing.
package pcsr_pkg;

   localparam int DEF_VECTOR_DEPTH = 1024;
   localparam int DEF_RESULT_ROWS  = 1024;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_NONZERO = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   typedef struct packed {
      logic clear_write;
      logic capture;
      logic vec_write;
      logic nz_read;
      logic mul;
      logic acc;
      logic row_write;
      logic rd_read;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rsp_free;
      logic seg_last;
   } status_type;

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      begin
         s = a + b;
         if ((a[63] == b[63]) && (s[63] != a[63])) begin
            return a[63] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
         end
         return s;
      end
   endfunction

endpackage

[rtl/pcsr_ctrl.sv]
// Sequencing controller of the partitioned CSR SpMV core.
// Depends on pcsr_pkg; drives the datapath through cmd_type.
module pcsr_ctrl
   import pcsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_opcode,
   output logic       req_stall,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_NZ_READ,
      S_NZ_MUL,
      S_NZ_ACC,
      S_NZ_ROW,
      S_RD_READ,
      S_RD_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_opcode)
                  OP_LOAD:    state_in = S_LOAD;
                  OP_NONZERO: state_in = S_NZ_READ;
                  OP_READ:    state_in = S_RD_READ;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD:    state_in = S_IDLE;
         S_NZ_READ: state_in = S_NZ_MUL;
         S_NZ_MUL:  state_in = S_NZ_ACC;
         S_NZ_ACC:  state_in = status.seg_last ? S_NZ_ROW : S_IDLE;
         S_NZ_ROW:  state_in = S_IDLE;
         S_RD_READ: state_in = S_RD_RESP;
         S_RD_RESP: begin
            if (status.rsp_free) state_in = S_IDLE;
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         stall_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != S_IDLE);
      end
   end

   assign req_stall = stall_ff;

   always_comb begin
      cmd             = '0;
      cmd.clear_write = (state_ff == S_CLEAR);
      cmd.capture     = (state_ff == S_IDLE);
      cmd.vec_write   = (state_ff == S_LOAD);
      cmd.nz_read     = (state_ff == S_NZ_READ);
      cmd.mul         = (state_ff == S_NZ_MUL);
      cmd.acc         = (state_ff == S_NZ_ACC);
      cmd.row_write   = (state_ff == S_NZ_ROW);
      cmd.rd_read     = (state_ff == S_RD_READ);
      cmd.rsp_load    = (state_ff == S_RD_RESP) && status.rsp_free;
   end

endmodule

[rtl/pcsr_datapath.sv]
// Datapath of the partitioned CSR SpMV core: x and y memories, multiplier,
// saturating accumulators and result register. Depends on pcsr_pkg.
`include "partitioned_csr_spmv_core_assert.svh"
module pcsr_datapath
   import pcsr_pkg::*;
#(
   parameter int VECTOR_DEPTH = DEF_VECTOR_DEPTH,
   parameter int RESULT_ROWS  = DEF_RESULT_ROWS
)
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [9:0]         req_index,
   input  logic [9:0]         req_col_base,
   input  logic [15:0]        req_col_offset,
   input  logic [9:0]         req_row,
   input  logic signed [31:0] req_value,
   input  logic               req_seg_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [9:0]         rsp_row_index,
   output logic signed [63:0] rsp_y_value,
   output logic               rsp_overrun
);

   localparam int VAW = $clog2(VECTOR_DEPTH);
   localparam int RAW = $clog2(RESULT_ROWS);
   localparam logic [RAW-1:0] LAST_ROW = RAW'(RESULT_ROWS - 1);

   logic [9:0]         index_ff;
   logic [9:0]         col_base_ff;
   logic [15:0]        col_offset_ff;
   logic [9:0]         row_ff;
   logic signed [31:0] value_ff;
   logic               seg_last_ff;

   logic [31:0] vec_mem_ff [VECTOR_DEPTH];
   logic [63:0] y_mem_ff   [RESULT_ROWS];
   logic [31:0] vec_rdata_ff;
   logic [63:0] y_rdata_ff;

   logic               col_ok_ff;
   logic signed [63:0] prod_ff;
   logic [63:0]        seg_sum_ff;
   logic               overrun_ff;
   logic [RAW-1:0]     clr_addr_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [9:0]         rsp_row_index_ff;
   logic [63:0]        rsp_y_value_ff;
   logic               rsp_overrun_ff;

   logic [16:0]        col;
   logic [31:0]        col_ext, index_ext, row_ext;
   logic               col_ok, load_ok, row_ok, rd_ok;
   logic [VAW-1:0]     col_vaddr, load_vaddr;
   logic [RAW-1:0]     row_yaddr, index_yaddr;
   logic signed [31:0] x_sel;
   logic signed [63:0] prod;
   logic               rsp_free;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         index_ff      <= req_index;
         col_base_ff   <= req_col_base;
         col_offset_ff <= req_col_offset;
         row_ff        <= req_row;
         value_ff      <= req_value;
         seg_last_ff   <= req_seg_last;
      end
   end

   assign col         = 17'(col_base_ff) + 17'(col_offset_ff);
   assign col_ext     = 32'(col);
   assign index_ext   = 32'(index_ff);
   assign row_ext     = 32'(row_ff);
   assign col_ok      = col_ext < 32'(VECTOR_DEPTH);
   assign load_ok     = index_ext < 32'(VECTOR_DEPTH);
   assign row_ok      = row_ext < 32'(RESULT_ROWS);
   assign rd_ok       = index_ext < 32'(RESULT_ROWS);
   assign col_vaddr   = col_ext[VAW-1:0];
   assign load_vaddr  = index_ext[VAW-1:0];
   assign row_yaddr   = row_ext[RAW-1:0];
   assign index_yaddr = index_ext[RAW-1:0];

   // x memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.vec_write && load_ok) begin
         vec_mem_ff[load_vaddr] <= value_ff;
      end
      if (cmd.nz_read) begin
         vec_rdata_ff <= vec_mem_ff[col_vaddr];
      end
   end

   // y memory: read-first, so a read-and-clear returns the old entry
   always_ff @(posedge clock) begin
      priority if (cmd.clear_write) begin
         y_mem_ff[clr_addr_ff] <= '0;
      end else if (cmd.row_write && row_ok) begin
         y_mem_ff[row_yaddr] <= sat_add64(y_rdata_ff, seg_sum_ff);
      end else if (cmd.rd_read && rd_ok) begin
         y_mem_ff[index_yaddr] <= '0;
      end
      priority if (cmd.nz_read) begin
         y_rdata_ff <= y_mem_ff[row_yaddr];
      end else if (cmd.rd_read) begin
         y_rdata_ff <= y_mem_ff[index_yaddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.nz_read) col_ok_ff <= col_ok;
      if (cmd.mul) prod_ff <= prod;
   end

   assign x_sel = col_ok_ff ? signed'(vec_rdata_ff) : 32'sd0;
   assign prod  = x_sel * value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_sum_ff  <= '0;
         overrun_ff  <= 1'b0;
         clr_addr_ff <= '0;
      end else begin
         if (cmd.acc) begin
            seg_sum_ff <= sat_add64(seg_sum_ff, prod_ff);
         end else if (cmd.row_write) begin
            seg_sum_ff <= '0;
         end
         if (cmd.mul && !col_ok_ff) overrun_ff <= 1'b1;
         if (cmd.clear_write) clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_row_index_ff <= index_ff;
         rsp_y_value_ff   <= rd_ok ? y_rdata_ff : 64'd0;
         rsp_overrun_ff   <= overrun_ff;
      end
   end

   assign status.clear_last = (clr_addr_ff == LAST_ROW);
   assign status.rsp_free   = rsp_free;
   assign status.seg_last   = seg_last_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_index_ff;
   assign rsp_y_value   = signed'(rsp_y_value_ff);
   assign rsp_overrun   = rsp_overrun_ff;

   `PCSR_ASSERT_NEXT(a_overrun_sticky, clock, reset, overrun_ff, overrun_ff)
   `PCSR_ASSERT_SAME(a_rsp_from_load, clock, reset, $rose(rsp_valid_ff), $past(cmd.rsp_load))
   `PCSR_ASSERT_NEXT(a_seg_cleared, clock, reset, cmd.row_write, seg_sum_ff == 64'd0)

endmodule

[rtl/partitioned_csr_spmv_core.sv]
// Partitioned CSR SpMV core: top level, controller plus datapath. Depends on pcsr_pkg.
// Load transaction: one x memory write. Nonzero: x read, 32x32 multiply, segment add,
// and a y read-modify-write when it closes a segment, one step each.
// Read transaction: y read, then a registered response load that waits out rsp_stall.
// Reset: synchronous; then a pass clearing every y entry, with req_stall high.
module partitioned_csr_spmv_core
   import pcsr_pkg::*;
#(
   parameter int VECTOR_DEPTH = DEF_VECTOR_DEPTH,
   parameter int RESULT_ROWS  = DEF_RESULT_ROWS
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [9:0]         req_index,
   input  logic [9:0]         req_col_base,
   input  logic [15:0]        req_col_offset,
   input  logic [9:0]         req_row,
   input  logic signed [31:0] req_value,
   input  logic               req_seg_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [9:0]         rsp_row_index,
   output logic signed [63:0] rsp_y_value,
   output logic               rsp_overrun
);

   cmd_type    cmd;
   status_type status;

   pcsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .status     (status)
   );

   pcsr_datapath #(
      .VECTOR_DEPTH (VECTOR_DEPTH),
      .RESULT_ROWS  (RESULT_ROWS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_index      (req_index),
      .req_col_base   (req_col_base),
      .req_col_offset (req_col_offset),
      .req_row        (req_row),
      .req_value      (req_value),
      .req_seg_last   (req_seg_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_index  (rsp_row_index),
      .rsp_y_value    (rsp_y_value),
      .rsp_overrun    (rsp_overrun)
   );

endmodule
